// ===== rtl/core/cir_pkg.sv =====
// Package for the contact impulse resolver: shared field widths, pipeline
// control struct and body velocity struct.
// No dependencies.
package cir_pkg;

	localparam int VEL_W  = 32;
	localparam int NRM_W  = 18;
	localparam int RST_W  = 17;
	localparam int MASS_W = 31;
	localparam int SUM_W  = 32;
	localparam int REL_W  = 33;
	localparam int PROD_W = 51;
	localparam int DOT_W  = 52;
	localparam int J_W    = 40;

	// Control bits that travel down the pipeline with each contact.
	typedef struct packed {
		logic valid;
		logic appr;
		logic fault;
	} ctl_t;

	// Velocities of both bodies.
	typedef struct packed {
		logic signed [VEL_W-1:0] ax;
		logic signed [VEL_W-1:0] ay;
		logic signed [VEL_W-1:0] bx;
		logic signed [VEL_W-1:0] by;
	} body_vel_t;

endpackage

// ===== rtl/core/cir_front.sv =====
// Front end of the contact impulse resolver: relative velocity, normal
// projection, approach test and impulse numerator. Depends on cir_pkg.
module cir_front import cir_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic signed [VEL_W-1:0]  a_vel_x,
	input  logic signed [VEL_W-1:0]  a_vel_y,
	input  logic signed [VEL_W-1:0]  b_vel_x,
	input  logic signed [VEL_W-1:0]  b_vel_y,
	input  logic signed [NRM_W-1:0]  normal_x,
	input  logic signed [NRM_W-1:0]  normal_y,
	input  logic [RST_W-1:0]         a_restitution,
	input  logic [RST_W-1:0]         b_restitution,
	input  logic [MASS_W-1:0]        a_inv_mass,
	input  logic [MASS_W-1:0]        b_inv_mass,
	input  logic [MASS_W-1:0]        a_mass,
	input  logic [MASS_W-1:0]        b_mass,
	output ctl_t                     ctl_o,
	output body_vel_t                vel_o,
	output logic signed [NRM_W-1:0]  nx_o,
	output logic signed [NRM_W-1:0]  ny_o,
	output logic [FRAC_BITS+(FRAC_BITS > RST_W ? FRAC_BITS : RST_W)-FRAC_BITS+DOT_W-FRAC_BITS:0]
	                                 num_o,
	output logic [SUM_W-1:0]         invsum_o,
	output logic [SUM_W-1:0]         msum_o,
	output logic [MASS_W-1:0]        ma_o,
	output logic [MASS_W-1:0]        mb_o
);

	localparam int VN_W  = DOT_W - FRAC_BITS;
	localparam int FAC_W = (FRAC_BITS > RST_W ? FRAC_BITS : RST_W) + 1;
	localparam int NUM_W = FAC_W + VN_W;

	logic                     v_s1, v_s2, v_s3, v_s4;
	logic signed [REL_W-1:0]  rx_s1, ry_s1;
	logic [SUM_W-1:0]         inv_s1, inv_s2, inv_s3, inv_s4;
	logic [SUM_W-1:0]         ms_s1, ms_s2, ms_s3, ms_s4;
	logic [RST_W-1:0]         e_s1, e_s2;
	body_vel_t                vel_s1, vel_s2, vel_s3, vel_s4;
	logic signed [NRM_W-1:0]  nx_s1, nx_s2, nx_s3, nx_s4;
	logic signed [NRM_W-1:0]  ny_s1, ny_s2, ny_s3, ny_s4;
	logic [MASS_W-1:0]        ma_s1, ma_s2, ma_s3, ma_s4;
	logic [MASS_W-1:0]        mb_s1, mb_s2, mb_s3, mb_s4;
	logic signed [PROD_W-1:0] px_s2, py_s2;
	logic [VN_W-1:0]          nvn_s3;
	logic [FAC_W-1:0]         fac_s3;
	logic                     ap_s3, ap_s4, fl_s3, fl_s4;
	logic [NUM_W-1:0]         num_s4;
	logic signed [DOT_W-1:0]  dot;
	logic signed [VN_W-1:0]   vn;
	logic                     appr;

	// Valid bits of the four stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Stage 1: relative velocity, divisor sums and the smaller restitution.
	always_ff @(posedge clk) begin
		if (en) begin
			rx_s1  <= REL_W'(b_vel_x) - REL_W'(a_vel_x);
			ry_s1  <= REL_W'(b_vel_y) - REL_W'(a_vel_y);
			inv_s1 <= SUM_W'(a_inv_mass) + SUM_W'(b_inv_mass);
			ms_s1  <= SUM_W'(a_mass) + SUM_W'(b_mass);
			e_s1   <= (a_restitution < b_restitution) ? a_restitution : b_restitution;
			vel_s1 <= '{ax: a_vel_x, ay: a_vel_y, bx: b_vel_x, by: b_vel_y};
			nx_s1  <= normal_x;
			ny_s1  <= normal_y;
			ma_s1  <= a_mass;
			mb_s1  <= b_mass;
		end
	end

	// Stage 2: the two products of the projection.
	always_ff @(posedge clk) begin
		if (en) begin
			px_s2  <= PROD_W'(rx_s1) * PROD_W'(nx_s1);
			py_s2  <= PROD_W'(ry_s1) * PROD_W'(ny_s1);
			inv_s2 <= inv_s1;
			ms_s2  <= ms_s1;
			e_s2   <= e_s1;
			vel_s2 <= vel_s1;
			nx_s2  <= nx_s1;
			ny_s2  <= ny_s1;
			ma_s2  <= ma_s1;
			mb_s2  <= mb_s1;
		end
	end

	// The normal speed is the floored projection; zero or below means approach.
	assign dot  = DOT_W'(px_s2) + DOT_W'(py_s2);
	assign vn   = VN_W'(dot >>> FRAC_BITS);
	assign appr = vn[VN_W-1] || (vn == '0);

	// Stage 3: negated normal speed, restitution factor and divisor check.
	always_ff @(posedge clk) begin
		if (en) begin
			nvn_s3 <= VN_W'(-vn);
			fac_s3 <= FAC_W'(1 << FRAC_BITS) + FAC_W'(e_s2);
			ap_s3  <= appr;
			fl_s3  <= appr && ((inv_s2 == '0) || (ms_s2 == '0));
			inv_s3 <= inv_s2;
			ms_s3  <= ms_s2;
			vel_s3 <= vel_s2;
			nx_s3  <= nx_s2;
			ny_s3  <= ny_s2;
			ma_s3  <= ma_s2;
			mb_s3  <= mb_s2;
		end
	end

	// Stage 4: impulse numerator.
	always_ff @(posedge clk) begin
		if (en) begin
			num_s4 <= NUM_W'(fac_s3) * NUM_W'(nvn_s3);
			ap_s4  <= ap_s3;
			fl_s4  <= fl_s3;
			inv_s4 <= inv_s3;
			ms_s4  <= ms_s3;
			vel_s4 <= vel_s3;
			nx_s4  <= nx_s3;
			ny_s4  <= ny_s3;
			ma_s4  <= ma_s3;
			mb_s4  <= mb_s3;
		end
	end

	assign ctl_o    = '{valid: v_s4, appr: ap_s4, fault: fl_s4};
	assign vel_o    = vel_s4;
	assign nx_o     = nx_s4;
	assign ny_o     = ny_s4;
	assign num_o    = num_s4;
	assign invsum_o = inv_s4;
	assign msum_o   = ms_s4;
	assign ma_o     = ma_s4;
	assign mb_o     = mb_s4;

endmodule

// ===== rtl/core/cir_div.sv =====
// Pipelined restoring dividers of the contact impulse resolver: the impulse
// quotient and both mass ratios, one quotient bit per stage. Depends on cir_pkg.
module cir_div import cir_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  ctl_t                     ctl_i,
	input  body_vel_t                vel_i,
	input  logic signed [NRM_W-1:0]  nx_i,
	input  logic signed [NRM_W-1:0]  ny_i,
	input  logic [FRAC_BITS+(FRAC_BITS > RST_W ? FRAC_BITS : RST_W)-FRAC_BITS+DOT_W-FRAC_BITS:0]
	                                 num_i,
	input  logic [SUM_W-1:0]         invsum_i,
	input  logic [SUM_W-1:0]         msum_i,
	input  logic [MASS_W-1:0]        ma_i,
	input  logic [MASS_W-1:0]        mb_i,
	output ctl_t                     ctl_o,
	output body_vel_t                vel_o,
	output logic signed [NRM_W-1:0]  nx_o,
	output logic signed [NRM_W-1:0]  ny_o,
	output logic [J_W-1:0]           j_o,
	output logic [FRAC_BITS:0]       rat_a_o,
	output logic [FRAC_BITS:0]       rat_b_o
);

	localparam int VN_W  = DOT_W - FRAC_BITS;
	localparam int FAC_W = (FRAC_BITS > RST_W ? FRAC_BITS : RST_W) + 1;
	localparam int NUM_W = FAC_W + VN_W;
	localparam int RAT_W = FRAC_BITS + 1;

	// Stage arrays: entry 0 is the set-up stage, entry k+1 follows step k.
	ctl_t                    ctl_s [0:J_W];
	body_vel_t               vel_s [0:J_W];
	logic signed [NRM_W-1:0] nx_s  [0:J_W];
	logic signed [NRM_W-1:0] ny_s  [0:J_W];
	logic [SUM_W-1:0]        rem_s [0:J_W];
	logic [J_W-1:0]          nlo_s [0:J_W];
	logic [J_W-1:0]          q_s   [0:J_W];
	logic                    sat_s [0:J_W];
	logic [SUM_W-1:0]        dv_s  [0:J_W];
	logic [SUM_W-1:0]        ms_s  [0:J_W];
	logic [SUM_W-1:0]        ra_s  [0:J_W];
	logic [SUM_W-1:0]        rb_s  [0:J_W];
	logic [RAT_W-1:0]        qa_s  [0:J_W];
	logic [RAT_W-1:0]        qb_s  [0:J_W];
	logic [SUM_W-1:0]        num_hi;

	// A numerator whose top part reaches the divisor gives a quotient that saturates.
	assign num_hi = SUM_W'(num_i[NUM_W-1:J_W]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s[0] <= '0;
		end else if (en) begin
			ctl_s[0] <= ctl_i;
		end
	end

	// Set-up stage: saturation test and initial partial remainders.
	always_ff @(posedge clk) begin
		if (en) begin
			sat_s[0] <= (num_hi >= invsum_i);
			rem_s[0] <= num_hi;
			nlo_s[0] <= num_i[J_W-1:0];
			q_s[0]   <= '0;
			dv_s[0]  <= invsum_i;
			ms_s[0]  <= msum_i;
			ra_s[0]  <= SUM_W'(ma_i);
			rb_s[0]  <= SUM_W'(mb_i);
			qa_s[0]  <= '0;
			qb_s[0]  <= '0;
			vel_s[0] <= vel_i;
			nx_s[0]  <= nx_i;
			ny_s[0]  <= ny_i;
		end
	end

	for (genvar k = 0; k < J_W; k++) begin : g_step
		logic [SUM_W:0] trial;
		logic           ge;

		// One restoring step of the impulse division.
		assign trial = {rem_s[k], nlo_s[k][J_W-1-k]};
		assign ge    = (trial >= {1'b0, dv_s[k]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k+1] <= '0;
			end else if (en) begin
				ctl_s[k+1] <= ctl_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? SUM_W'(trial - {1'b0, dv_s[k]}) : SUM_W'(trial);
				q_s[k+1]   <= q_s[k] | (ge ? (J_W'(1) << (J_W-1-k)) : '0);
				nlo_s[k+1] <= nlo_s[k];
				sat_s[k+1] <= sat_s[k];
				dv_s[k+1]  <= dv_s[k];
				ms_s[k+1]  <= ms_s[k];
				vel_s[k+1] <= vel_s[k];
				nx_s[k+1]  <= nx_s[k];
				ny_s[k+1]  <= ny_s[k];
			end
		end

		// The mass ratios need only the first FRAC_BITS+1 steps.
		if (k <= FRAC_BITS) begin : g_rat
			logic [SUM_W:0] ta, tb;
			logic           gea, geb;

			assign ta  = (k == 0) ? {1'b0, ra_s[k]} : {ra_s[k], 1'b0};
			assign tb  = (k == 0) ? {1'b0, rb_s[k]} : {rb_s[k], 1'b0};
			assign gea = (ta >= {1'b0, ms_s[k]});
			assign geb = (tb >= {1'b0, ms_s[k]});

			always_ff @(posedge clk) begin
				if (en) begin
					ra_s[k+1] <= gea ? SUM_W'(ta - {1'b0, ms_s[k]}) : SUM_W'(ta);
					rb_s[k+1] <= geb ? SUM_W'(tb - {1'b0, ms_s[k]}) : SUM_W'(tb);
					qa_s[k+1] <= qa_s[k] | (gea ? (RAT_W'(1) << (FRAC_BITS-k)) : '0);
					qb_s[k+1] <= qb_s[k] | (geb ? (RAT_W'(1) << (FRAC_BITS-k)) : '0);
				end
			end
		end else begin : g_hold
			always_ff @(posedge clk) begin
				if (en) begin
					ra_s[k+1] <= ra_s[k];
					rb_s[k+1] <= rb_s[k];
					qa_s[k+1] <= qa_s[k];
					qb_s[k+1] <= qb_s[k];
				end
			end
		end
	end

	assign ctl_o   = ctl_s[J_W];
	assign vel_o   = vel_s[J_W];
	assign nx_o    = nx_s[J_W];
	assign ny_o    = ny_s[J_W];
	assign j_o     = sat_s[J_W] ? '1 : q_s[J_W];
	assign rat_a_o = qa_s[J_W];
	assign rat_b_o = qb_s[J_W];

endmodule

// ===== rtl/core/cir_apply.sv =====
// Impulse application of the contact impulse resolver: impulse vector, mass
// shares, new velocities with saturation and the result register. Depends on cir_pkg.
module cir_apply import cir_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  ctl_t                     ctl_i,
	input  body_vel_t                vel_i,
	input  logic signed [NRM_W-1:0]  nx_i,
	input  logic signed [NRM_W-1:0]  ny_i,
	input  logic [J_W-1:0]           j_i,
	input  logic [FRAC_BITS:0]       rat_a_i,
	input  logic [FRAC_BITS:0]       rat_b_i,
	output logic                     out_valid,
	output logic signed [VEL_W-1:0]  a_vel_x_new,
	output logic signed [VEL_W-1:0]  a_vel_y_new,
	output logic signed [VEL_W-1:0]  b_vel_x_new,
	output logic signed [VEL_W-1:0]  b_vel_y_new,
	output logic                     impulse_applied,
	output logic                     divide_fault
);

	localparam int RAT_W = FRAC_BITS + 1;
	localparam int IP_W  = NRM_W + J_W + 1;
	localparam int IX_W  = IP_W - FRAC_BITS;
	localparam int DP_W  = IX_W + RAT_W + 1;
	localparam int D_W   = DP_W - FRAC_BITS;
	localparam int S_W   = D_W + 1;

	ctl_t                     ctl_s1, ctl_s2;
	body_vel_t                vel_s1, vel_s2;
	logic signed [IX_W-1:0]   ix_s1, iy_s1;
	logic [RAT_W-1:0]         ra_s1, rb_s1;
	logic signed [D_W-1:0]    dax_s2, day_s2, dbx_s2, dby_s2;
	logic signed [VEL_W-1:0]  ax_s3, ay_s3, bx_s3, by_s3;
	logic                     v_s3, app_s3, flt_s3;
	logic signed [IP_W-1:0]   jx;
	logic signed [RAT_W:0]    rsa, rsb;
	logic                     applied;

	// Clamp a wide signed value to the 32-bit velocity range.
	function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [S_W-1:0] v);
		logic signed [S_W-1:0] hi, lo;
		hi = S_W'(signed'({1'b0, {(VEL_W-1){1'b1}}}));
		lo = S_W'(signed'({1'b1, {(VEL_W-1){1'b0}}}));
		if (v > hi) begin
			sat_vel = hi[VEL_W-1:0];
		end else if (v < lo) begin
			sat_vel = lo[VEL_W-1:0];
		end else begin
			sat_vel = v[VEL_W-1:0];
		end
	endfunction

	assign jx      = signed'({{(NRM_W){1'b0}}, 1'b0, j_i});
	assign rsa     = signed'({1'b0, ra_s1});
	assign rsb     = signed'({1'b0, rb_s1});
	assign applied = ctl_s2.appr && !ctl_s2.fault;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			v_s3   <= 1'b0;
		end else if (en) begin
			ctl_s1 <= ctl_i;
			ctl_s2 <= ctl_s1;
			v_s3   <= ctl_s2.valid;
		end
	end

	// Stage 1: impulse vector along the normal.
	always_ff @(posedge clk) begin
		if (en) begin
			ix_s1  <= IX_W'((IP_W'(nx_i) * jx) >>> FRAC_BITS);
			iy_s1  <= IX_W'((IP_W'(ny_i) * jx) >>> FRAC_BITS);
			ra_s1  <= rat_a_i;
			rb_s1  <= rat_b_i;
			vel_s1 <= vel_i;
		end
	end

	// Stage 2: each body's share of the impulse.
	always_ff @(posedge clk) begin
		if (en) begin
			dax_s2 <= D_W'((DP_W'(ix_s1) * DP_W'(rsa)) >>> FRAC_BITS);
			day_s2 <= D_W'((DP_W'(iy_s1) * DP_W'(rsa)) >>> FRAC_BITS);
			dbx_s2 <= D_W'((DP_W'(ix_s1) * DP_W'(rsb)) >>> FRAC_BITS);
			dby_s2 <= D_W'((DP_W'(iy_s1) * DP_W'(rsb)) >>> FRAC_BITS);
			vel_s2 <= vel_s1;
		end
	end

	// Stage 3: new velocities; separating or faulted contacts pass unchanged.
	always_ff @(posedge clk) begin
		if (en) begin
			if (applied) begin
				ax_s3 <= sat_vel(S_W'(vel_s2.ax) - S_W'(dax_s2));
				ay_s3 <= sat_vel(S_W'(vel_s2.ay) - S_W'(day_s2));
				bx_s3 <= sat_vel(S_W'(vel_s2.bx) + S_W'(dbx_s2));
				by_s3 <= sat_vel(S_W'(vel_s2.by) + S_W'(dby_s2));
			end else begin
				ax_s3 <= vel_s2.ax;
				ay_s3 <= vel_s2.ay;
				bx_s3 <= vel_s2.bx;
				by_s3 <= vel_s2.by;
			end
			app_s3 <= applied;
			flt_s3 <= ctl_s2.fault;
		end
	end

	assign out_valid       = v_s3;
	assign a_vel_x_new     = ax_s3;
	assign a_vel_y_new     = ay_s3;
	assign b_vel_x_new     = bx_s3;
	assign b_vel_y_new     = by_s3;
	assign impulse_applied = app_s3;
	assign divide_fault    = flt_s3;

endmodule

// ===== rtl/core/contact_impulse_resolve.sv =====
// Contact impulse resolver: takes one two-body contact per cycle unless halted
// and returns the resolved velocities; the impulse is formed by a restoring
// divider of a set-up stage and 40 restoring stages, one quotient bit per
// stage. The whole pipeline halts while a result waits under out_stall, and
// takes a new contact in every cycle otherwise.
module contact_impulse_resolve import cir_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [VEL_W-1:0]  a_vel_x,
	input  logic signed [VEL_W-1:0]  a_vel_y,
	input  logic signed [VEL_W-1:0]  b_vel_x,
	input  logic signed [VEL_W-1:0]  b_vel_y,
	input  logic signed [NRM_W-1:0]  normal_x,
	input  logic signed [NRM_W-1:0]  normal_y,
	input  logic [RST_W-1:0]         a_restitution,
	input  logic [RST_W-1:0]         b_restitution,
	input  logic [MASS_W-1:0]        a_inv_mass,
	input  logic [MASS_W-1:0]        b_inv_mass,
	input  logic [MASS_W-1:0]        a_mass,
	input  logic [MASS_W-1:0]        b_mass,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [VEL_W-1:0]  a_vel_x_new,
	output logic signed [VEL_W-1:0]  a_vel_y_new,
	output logic signed [VEL_W-1:0]  b_vel_x_new,
	output logic signed [VEL_W-1:0]  b_vel_y_new,
	output logic                     impulse_applied,
	output logic                     divide_fault
);

	localparam int VN_W  = DOT_W - FRAC_BITS;
	localparam int FAC_W = (FRAC_BITS > RST_W ? FRAC_BITS : RST_W) + 1;
	localparam int NUM_W = FAC_W + VN_W;

	logic                    adv;
	ctl_t                    f_ctl, d_ctl;
	body_vel_t               f_vel, d_vel;
	logic signed [NRM_W-1:0] f_nx, f_ny, d_nx, d_ny;
	logic [NUM_W-1:0]        f_num;
	logic [SUM_W-1:0]        f_inv, f_ms;
	logic [MASS_W-1:0]       f_ma, f_mb;
	logic [J_W-1:0]          d_j;
	logic [FRAC_BITS:0]      d_ra, d_rb;

	// The pipeline moves unless a finished result is held by the consumer.
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	cir_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(in_valid),
		.a_vel_x(a_vel_x), .a_vel_y(a_vel_y), .b_vel_x(b_vel_x), .b_vel_y(b_vel_y),
		.normal_x(normal_x), .normal_y(normal_y),
		.a_restitution(a_restitution), .b_restitution(b_restitution),
		.a_inv_mass(a_inv_mass), .b_inv_mass(b_inv_mass),
		.a_mass(a_mass), .b_mass(b_mass),
		.ctl_o(f_ctl), .vel_o(f_vel), .nx_o(f_nx), .ny_o(f_ny), .num_o(f_num),
		.invsum_o(f_inv), .msum_o(f_ms), .ma_o(f_ma), .mb_o(f_mb)
	);

	cir_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.ctl_i(f_ctl), .vel_i(f_vel), .nx_i(f_nx), .ny_i(f_ny), .num_i(f_num),
		.invsum_i(f_inv), .msum_i(f_ms), .ma_i(f_ma), .mb_i(f_mb),
		.ctl_o(d_ctl), .vel_o(d_vel), .nx_o(d_nx), .ny_o(d_ny), .j_o(d_j),
		.rat_a_o(d_ra), .rat_b_o(d_rb)
	);

	cir_apply #(.FRAC_BITS(FRAC_BITS)) u_apply (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.ctl_i(d_ctl), .vel_i(d_vel), .nx_i(d_nx), .ny_i(d_ny), .j_i(d_j),
		.rat_a_i(d_ra), .rat_b_i(d_rb),
		.out_valid(out_valid),
		.a_vel_x_new(a_vel_x_new), .a_vel_y_new(a_vel_y_new),
		.b_vel_x_new(b_vel_x_new), .b_vel_y_new(b_vel_y_new),
		.impulse_applied(impulse_applied), .divide_fault(divide_fault)
	);

	// A divisor fault is only ever raised for an approaching contact.
	a_fault_appr: assert property (@(posedge clk) disable iff (!arst_n)
		f_ctl.valid && f_ctl.fault |-> f_ctl.appr)
		else $error("divisor fault flagged on a separating contact");

	// A result never reports both an applied impulse and a fault.
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(impulse_applied && divide_fault))
		else $error("impulse applied and divide fault both set");

	// A contact inside the divider is not lost while the pipeline is halted.
	a_div_hold: assert property (@(posedge clk) disable iff (!arst_n)
		d_ctl.valid && !adv |=> d_ctl.valid)
		else $error("divider output lost during a halt");

endmodule

// ===== verif/resolve_checker.sv =====
// Checker for the contact impulse resolver: watches both channels, predicts
// each resolved contact and compares it with what the block returns.
// Depends on cir_pkg for the field widths.
`timescale 1ns / 1ps
module resolve_checker import cir_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    in_stall,
	input  logic signed [VEL_W-1:0] a_vel_x,
	input  logic signed [VEL_W-1:0] a_vel_y,
	input  logic signed [VEL_W-1:0] b_vel_x,
	input  logic signed [VEL_W-1:0] b_vel_y,
	input  logic signed [NRM_W-1:0] normal_x,
	input  logic signed [NRM_W-1:0] normal_y,
	input  logic [RST_W-1:0]        a_restitution,
	input  logic [RST_W-1:0]        b_restitution,
	input  logic [MASS_W-1:0]       a_inv_mass,
	input  logic [MASS_W-1:0]       b_inv_mass,
	input  logic [MASS_W-1:0]       a_mass,
	input  logic [MASS_W-1:0]       b_mass,
	input  logic                    out_valid,
	input  logic                    out_stall,
	input  logic signed [VEL_W-1:0] a_vel_x_new,
	input  logic signed [VEL_W-1:0] a_vel_y_new,
	input  logic signed [VEL_W-1:0] b_vel_x_new,
	input  logic signed [VEL_W-1:0] b_vel_y_new,
	input  logic                    impulse_applied,
	input  logic                    divide_fault,
	output int                      fail_count,
	output int                      pending,
	output int                      applied_count,
	output int                      fault_count
);

	localparam longint J_LIMIT = 64'hFF_FFFF_FFFF;

	typedef struct packed {
		logic signed [VEL_W-1:0] ax;
		logic signed [VEL_W-1:0] ay;
		logic signed [VEL_W-1:0] bx;
		logic signed [VEL_W-1:0] by;
		logic                    applied;
		logic                    fault;
	} resolved_t;

	resolved_t resolved_q[$];

	function automatic logic signed [VEL_W-1:0] clamp32(longint v);
		if (v > 64'sd2147483647)
			return 32'sh7FFF_FFFF;
		if (v < -64'sd2147483648)
			return 32'sh8000_0000;
		return v[VEL_W-1:0];
	endfunction

	// Works out the resolved velocities of the contact presented on the input.
	function automatic resolved_t resolve_contact();
		resolved_t r;
		longint ax, ay, bx, by, nx, ny, dot, vn, invsum, msum, e, num, j;
		longint ratio_a, ratio_b, ix, iy;
		ax = longint'(a_vel_x);
		ay = longint'(a_vel_y);
		bx = longint'(b_vel_x);
		by = longint'(b_vel_y);
		nx = longint'(normal_x);
		ny = longint'(normal_y);
		r = '{ax: a_vel_x, ay: a_vel_y, bx: b_vel_x, by: b_vel_y, applied: 1'b0,
			fault: 1'b0};
		dot = (bx - ax) * nx + (by - ay) * ny;
		vn = dot >>> FRAC_BITS;
		if (vn <= 0) begin
			invsum = longint'({1'b0, a_inv_mass}) + longint'({1'b0, b_inv_mass});
			msum = longint'({1'b0, a_mass}) + longint'({1'b0, b_mass});
			if (invsum == 0 || msum == 0) begin
				r.fault = 1'b1;
			end else begin
				e = (a_restitution < b_restitution) ? longint'({1'b0, a_restitution})
					: longint'({1'b0, b_restitution});
				num = ((longint'(1) <<< FRAC_BITS) + e) * (-vn);
				j = num / invsum;
				if (j > J_LIMIT)
					j = J_LIMIT;
				ratio_a = (longint'({1'b0, a_mass}) <<< FRAC_BITS) / msum;
				ratio_b = (longint'({1'b0, b_mass}) <<< FRAC_BITS) / msum;
				ix = (nx * j) >>> FRAC_BITS;
				iy = (ny * j) >>> FRAC_BITS;
				r.ax = clamp32(ax - ((ix * ratio_a) >>> FRAC_BITS));
				r.ay = clamp32(ay - ((iy * ratio_a) >>> FRAC_BITS));
				r.bx = clamp32(bx + ((ix * ratio_b) >>> FRAC_BITS));
				r.by = clamp32(by + ((iy * ratio_b) >>> FRAC_BITS));
				r.applied = 1'b1;
			end
		end
		return r;
	endfunction

	// Queue a prediction for every input transfer and compare every output
	// transfer with the oldest one.
	always @(posedge clk or negedge arst_n) begin
		resolved_t want;
		if (!arst_n) begin
			fail_count <= 0;
			applied_count <= 0;
			fault_count <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				want = resolve_contact();
				resolved_q.push_back(want);
				applied_count <= applied_count + want.applied;
				fault_count <= fault_count + want.fault;
			end
			if (out_valid && !out_stall) begin
				if (resolved_q.size() == 0) begin
					$error("result transfer with no contact outstanding");
					fail_count <= fail_count + 1;
				end else begin
					want = resolved_q.pop_front();
					if ({a_vel_x_new, a_vel_y_new, b_vel_x_new, b_vel_y_new,
						impulse_applied, divide_fault} !== want) begin
						fail_count <= fail_count + 1;
						if (a_vel_x_new !== want.ax)
							$error("a_vel_x_new expected %0d got %0d", want.ax, a_vel_x_new);
						if (a_vel_y_new !== want.ay)
							$error("a_vel_y_new expected %0d got %0d", want.ay, a_vel_y_new);
						if (b_vel_x_new !== want.bx)
							$error("b_vel_x_new expected %0d got %0d", want.bx, b_vel_x_new);
						if (b_vel_y_new !== want.by)
							$error("b_vel_y_new expected %0d got %0d", want.by, b_vel_y_new);
						if (impulse_applied !== want.applied)
							$error("impulse_applied expected %0b got %0b", want.applied,
								impulse_applied);
						if (divide_fault !== want.fault)
							$error("divide_fault expected %0b got %0b", want.fault,
								divide_fault);
					end
				end
			end
		end
	end

	assign pending = resolved_q.size();

endmodule

// ===== verif/tb_top.sv =====
// Testbench top for the contact impulse resolver: drives directed and random
// contacts with random idling on both sides and gives the verdict.
// Depends on cir_pkg, contact_impulse_resolve and resolve_checker.
`timescale 1ns / 1ps
module tb_top import cir_pkg::*;;

	localparam int RANDOM_CONTACTS = 1400;
	localparam int LATENCY = 48;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [VEL_W-1:0] a_vel_x = '0, a_vel_y = '0, b_vel_x = '0, b_vel_y = '0;
	logic signed [NRM_W-1:0] normal_x = '0, normal_y = '0;
	logic [RST_W-1:0] a_restitution = '0, b_restitution = '0;
	logic [MASS_W-1:0] a_inv_mass = '0, b_inv_mass = '0, a_mass = '0, b_mass = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [VEL_W-1:0] a_vel_x_new, a_vel_y_new, b_vel_x_new, b_vel_y_new;
	logic impulse_applied, divide_fault;
	logic calm = 1'b0;
	int fail_count, pending, applied_count, fault_count;
	int cycle_count = 0;

	always #2 clk = ~clk;

	contact_impulse_resolve uut (.*);

	resolve_checker chk (.*);

	// Receiver idles at random, except during the calm stretch.
	always @(negedge clk)
		out_stall <= !calm && ($urandom_range(0, 99) < 24);

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Presents one contact and holds it until the transfer happens.
	task automatic send_contact(logic [31:0] ax, logic [31:0] ay, logic [31:0] bx,
		logic [31:0] by, logic [17:0] nx, logic [17:0] ny, logic [16:0] ra,
		logic [16:0] rb, logic [30:0] ia, logic [30:0] ib, logic [30:0] ma,
		logic [30:0] mb);
		a_vel_x = ax; a_vel_y = ay; b_vel_x = bx; b_vel_y = by;
		normal_x = nx; normal_y = ny; a_restitution = ra; b_restitution = rb;
		a_inv_mass = ia; b_inv_mass = ib; a_mass = ma; b_mass = mb;
		in_valid = 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
		in_valid = 1'b0;
		// Each further cycle is idle with the same chance, so about a quarter
		// of the sender's cycles are idle.
		while (!calm && $urandom_range(0, 99) < 24)
			@(negedge clk);
	endtask

	function automatic logic [31:0] pick_velocity();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
		endcase
	endfunction

	function automatic logic [17:0] pick_normal();
		if ($urandom_range(0, 4) == 0)
			return 18'($urandom);
		return 18'(int'($urandom_range(0, 131072)) - 65536);
	endfunction

	function automatic logic [16:0] pick_restitution();
		if ($urandom_range(0, 4) == 0)
			return 17'($urandom);
		return 17'($urandom_range(0, 65536));
	endfunction

	function automatic logic [30:0] pick_mass();
		case ($urandom_range(0, 9))
			0: return '0;
			1, 2: return 31'($urandom);
			default: return 31'($urandom_range(1 << 10, 1 << 22));
		endcase
	endfunction

	initial begin
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed contacts: all zero, separating, approaching, zero divisors, field
		// extremes, restitution above one and a saturated impulse.
		send_contact('0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0);
		send_contact(32'h0001_0000, '0, 32'h0003_0000, '0, 18'h10000, '0, 17'h8000,
			17'h4000, 31'h10000, 31'h10000, 31'h10000, 31'h10000);
		send_contact(32'h0003_0000, '0, 32'h0001_0000, '0, 18'h10000, '0, 17'h8000,
			17'h4000, 31'h10000, 31'h10000, 31'h10000, 31'h10000);
		send_contact(32'h0003_0000, '0, 32'h0001_0000, '0, 18'h10000, '0, 17'h8000,
			17'h4000, '0, '0, 31'h10000, 31'h10000);
		send_contact(32'h0003_0000, '0, 32'h0001_0000, '0, 18'h10000, '0, 17'h8000,
			17'h4000, 31'h10000, 31'h10000, '0, '0);
		send_contact(32'h0003_0000, 32'h0002_0000, '0, '0, 18'h0B505, 18'h0B505,
			17'h1FFFF, 17'h1FFFF, 31'h8000, 31'h4000, 31'h20000, 31'h40000);
		send_contact(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
			18'h1FFFF, 18'h1FFFF, 17'h10000, 17'h10000, 31'h1, 31'h0, 31'h7FFF_FFFF,
			31'h7FFF_FFFF);
		send_contact(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			18'h20000, 18'h20000, 17'h0, 17'h1FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
			31'h1, 31'h0);
		send_contact(32'h7FFF_FFFF, '0, 32'h8000_0000, '0, 18'h10000, 18'h0, '0, '0,
			31'h1, 31'h0, 31'h0, 31'h7FFF_FFFF);
		send_contact(32'h8000_0000, '0, 32'h7FFF_FFFF, '0, 18'h30000, 18'h0, '0, '0,
			31'h1, 31'h0, 31'h7FFF_FFFF, 31'h1);
		send_contact(32'hFFFF_FFFF, 32'h1, '0, '0, 18'h1, 18'h3FFFF, 17'h1, 17'h2,
			31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);

		// Random contacts, with a stretch of back-to-back traffic in the middle.
		for (int n = 0; n < RANDOM_CONTACTS; n++) begin
			calm = (n >= 600 && n < 800);
			send_contact(pick_velocity(), pick_velocity(), pick_velocity(),
				pick_velocity(), pick_normal(), pick_normal(), pick_restitution(),
				pick_restitution(), pick_mass(), pick_mass(), pick_mass(), pick_mass());
		end
		calm = 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);

		$display("Resolved %0d contacts: %0d with an impulse, %0d with a zero divisor.",
			RANDOM_CONTACTS + 11, applied_count, fault_count);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
